>>> rtl/peak_pixel_centroid_defines.svh
// ----------------------------------------------------------------------------
// Peak pixel centroid assertion macros
// Concurrent assertion helpers shared by the RTL files; clocked on clk,
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PEAK_PIXEL_CENTROID_DEFINES_SVH
`define PEAK_PIXEL_CENTROID_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define PPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define PPC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PPC_ASSERT(label, prop, msg)
`define PPC_ASSERT_NEVER(label, cond, msg)
`endif

`endif

>>> rtl/ppc_pkg.sv
// ----------------------------------------------------------------------------
// Peak pixel centroid package
// Widths, register indices, the front-to-back record and the size clamp.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int AREA_DIM      = 256;
    localparam int IMAGE_DIM     = 4096;
    localparam int FRACTION_BITS = 8;

    localparam int PIXEL_W    = 8;
    localparam int COORD_W    = $clog2(IMAGE_DIM);
    localparam int IDX_W      = $clog2(AREA_DIM);
    localparam int DIM_W      = IDX_W + 1;
    localparam int CNT_W      = $clog2(AREA_DIM * AREA_DIM + 1);
    localparam int SUM_W      = COORD_W + CNT_W - 1;
    localparam int DIVIDEND_W = SUM_W + FRACTION_BITS;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
    localparam int CENTROID_W = 20;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_AREA_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_TOP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 2'd3;

    // Totals of one finished area, handed from the front to the divider
    typedef struct packed {
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [PIXEL_W-1:0] peak;
        logic [CNT_W-1:0]   count;
    } area_sum_t;

    // Zero reads as one, anything above the area limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        priority if (d == '0)
            r = DIM_W'(1);
        else if (d > DIM_W'(AREA_DIM))
            r = DIM_W'(AREA_DIM);
        else
            r = d;
        return r;
    endfunction

endpackage

>>> rtl/ppc_front.sv
// ----------------------------------------------------------------------------
// Peak pixel centroid front end
// Holds the area registers, walks the raster position and keeps the running
// peak with the coordinate sums of its matches; hands totals on at area end.
// ----------------------------------------------------------------------------
module ppc_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           pix_accept,
    input  logic [ppc_pkg::PIXEL_W-1:0]    pixel_value,
    output logic                           sum_push,
    output ppc_pkg::area_sum_t             sum_data
);
    import ppc_pkg::*;

    logic [COORD_W-1:0] left_reg, top_reg;
    logic [DIM_W-1:0]   width_reg, height_reg;

    logic [IDX_W-1:0]   col_reg, col_next, row_reg, row_next;
    logic [PIXEL_W-1:0] peak_reg, peak_next;
    logic [SUM_W-1:0]   sumx_reg, sumx_next, sumy_reg, sumy_next;
    logic [CNT_W-1:0]   match_reg, match_next;

    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [COORD_W-1:0] x_pos, y_pos;
    logic               first_pix, last_col, last_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            top_reg    <= '0;
            width_reg  <= DIM_W'(AREA_DIM);
            height_reg <= DIM_W'(AREA_DIM);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AREA_LEFT:   left_reg   <= cfg_data;
                REG_AREA_TOP:    top_reg    <= cfg_data;
                REG_AREA_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                REG_AREA_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_eff     = clamp_dim(width_reg);
        h_eff     = clamp_dim(height_reg);
        x_pos     = left_reg + COORD_W'(col_reg);
        y_pos     = top_reg + COORD_W'(row_reg);
        first_pix = (col_reg == '0) && (row_reg == '0);
        last_col  = ({1'b0, col_reg} + DIM_W'(1)) >= w_eff;
        last_row  = ({1'b0, row_reg} + DIM_W'(1)) >= h_eff;

        peak_next  = peak_reg;
        sumx_next  = sumx_reg;
        sumy_next  = sumy_reg;
        match_next = match_reg;
        priority if (first_pix || (pixel_value > peak_reg))
        begin
            // restart the sums at this position
            peak_next  = pixel_value;
            sumx_next  = SUM_W'(x_pos);
            sumy_next  = SUM_W'(y_pos);
            match_next = CNT_W'(1);
        end
        else if (pixel_value == peak_reg)
        begin
            sumx_next  = sumx_reg + SUM_W'(x_pos);
            sumy_next  = sumy_reg + SUM_W'(y_pos);
            match_next = match_reg + CNT_W'(1);
        end

        col_next = last_col ? '0 : col_reg + IDX_W'(1);
        row_next = row_reg;
        if (last_col)
            row_next = last_row ? '0 : row_reg + IDX_W'(1);

        sum_push       = pix_accept && last_col && last_row;
        sum_data.sum_x = sumx_next;
        sum_data.sum_y = sumy_next;
        sum_data.peak  = peak_next;
        sum_data.count = match_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            peak_reg  <= '0;
            sumx_reg  <= '0;
            sumy_reg  <= '0;
            match_reg <= '0;
        end
        else if (pix_accept)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            peak_reg  <= peak_next;
            sumx_reg  <= sumx_next;
            sumy_reg  <= sumy_next;
            match_reg <= match_next;
        end
    end

`include "peak_pixel_centroid_defines.svh"

    `PPC_ASSERT(a_match_live, (col_reg != '0 || row_reg != '0) |-> match_reg != '0, "peak lost its matches mid-area")

endmodule

>>> rtl/ppc_queue.sv
// ----------------------------------------------------------------------------
// Peak pixel centroid area queue
// Short first-in first-out buffer of area totals between front and divider.
// ----------------------------------------------------------------------------
module ppc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ppc_pkg::area_sum_t wr_data,
    input  logic               pop,
    output ppc_pkg::area_sum_t rd_data,
    output logic               full,
    output logic               empty
);
    import ppc_pkg::*;

    area_sum_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
        empty       = (count_reg == '0);
        rd_data     = entry_reg[rd_ptr_reg];
        wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

`include "peak_pixel_centroid_defines.svh"

    `PPC_ASSERT_NEVER(a_no_overflow, push && !pop && full, "area queue overflow")
    `PPC_ASSERT_NEVER(a_no_underflow, pop && empty, "area queue underflow")

endmodule

>>> rtl/ppc_back.sv
// ----------------------------------------------------------------------------
// Peak pixel centroid back end
// Bit-serial restoring divider, x and y lanes side by side, sharing one
// divisor; finished results wait in a one-entry output register.
// ----------------------------------------------------------------------------
module ppc_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ppc_pkg::area_sum_t             q_data,
    input  logic                           q_empty,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [ppc_pkg::CENTROID_W-1:0] centroid_x,
    output logic [ppc_pkg::CENTROID_W-1:0] centroid_y,
    output logic [ppc_pkg::PIXEL_W-1:0]    peak_value,
    output logic [ppc_pkg::CNT_W-1:0]      peak_count
);
    import ppc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      divisor_reg;
    logic [CNT_W-1:0]      remx_reg, remx_next, remy_reg, remy_next;
    logic [DIVIDEND_W-1:0] quox_reg, quox_next, quoy_reg, quoy_next;
    logic [PIXEL_W-1:0]    peak_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [CENTROID_W-1:0] out_cx_reg, out_cy_reg;
    logic [PIXEL_W-1:0]    out_peak_reg;
    logic [CNT_W-1:0]      out_count_reg;

    logic [CNT_W:0]        shx, shy;
    logic                  gex, gey, slot_free, load_out;

    always_comb
    begin
        // one quotient bit per lane per cycle
        shx       = {remx_reg, quox_reg[DIVIDEND_W-1]};
        shy       = {remy_reg, quoy_reg[DIVIDEND_W-1]};
        gex       = shx >= {1'b0, divisor_reg};
        gey       = shy >= {1'b0, divisor_reg};
        remx_next = gex ? CNT_W'(shx - {1'b0, divisor_reg}) : CNT_W'(shx);
        remy_next = gey ? CNT_W'(shy - {1'b0, divisor_reg}) : CNT_W'(shy);
        quox_next = {quox_reg[DIVIDEND_W-2:0], gex};
        quoy_next = {quoy_reg[DIVIDEND_W-2:0], gey};

        slot_free = !out_valid_reg || pop;
        q_pop     = (state_reg == S_IDLE) && !q_empty;
        load_out  = (state_reg == S_HOLD) && slot_free;
        step_next = step_reg - STEP_W'(1);

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (!q_empty) state_next = S_DIV;
            S_DIV:   if (step_reg == STEP_W'(1)) state_next = S_HOLD;
            S_HOLD:  if (slot_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            remx_reg    <= '0;
            remy_reg    <= '0;
            quox_reg    <= {q_data.sum_x, FRACTION_BITS'(0)};
            quoy_reg    <= {q_data.sum_y, FRACTION_BITS'(0)};
            divisor_reg <= q_data.count;
            peak_reg    <= q_data.peak;
        end
        else if (state_reg == S_DIV)
        begin
            remx_reg <= remx_next;
            remy_reg <= remy_next;
            quox_reg <= quox_next;
            quoy_reg <= quoy_next;
        end
        if (load_out)
        begin
            out_cx_reg    <= quox_reg[CENTROID_W-1:0];
            out_cy_reg    <= quoy_reg[CENTROID_W-1:0];
            out_peak_reg  <= peak_reg;
            out_count_reg <= divisor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
                step_reg <= STEP_W'(DIVIDEND_W);
            else if (state_reg == S_DIV)
                step_reg <= step_next;
        end
    end

    assign empty      = !out_valid_reg;
    assign centroid_x = out_cx_reg;
    assign centroid_y = out_cy_reg;
    assign peak_value = out_peak_reg;
    assign peak_count = out_count_reg;

`include "peak_pixel_centroid_defines.svh"

    `PPC_ASSERT(a_div_steps, (state_reg == S_DIV) |-> step_reg != '0, "divider ran past its last step")
    `PPC_ASSERT(a_out_load, load_out |=> out_valid_reg && out_count_reg != '0, "result lost or empty on load")

endmodule

>>> rtl/peak_pixel_centroid.sv
// ----------------------------------------------------------------------------
// Peak pixel centroid
// Finds the brightest pixel value of an area of interest and the centroid
// of every pixel holding it, in unsigned fixed point with 8 fraction bits.
// ----------------------------------------------------------------------------
// Pixels of the area arrive in raster order, one transfer per pixel, and are
// taken one per clock unless full: the front end updates the running peak,
// the match count and the x and y coordinate sums per pixel. Coordinates are
// area_left plus column and area_top plus row, wrapping at the image size;
// width and height of zero act as one and above 256 as 256. After the
// area's last pixel the totals drop into a two-entry queue, and a bit-serial
// divider turns them into centroid_x and centroid_y, one quotient bit per
// cycle: it takes an area from the queue while idle, divides, then moves the
// result to the output register, and takes no new area before that move.
// Full rises only while two finished areas are queued behind the divider,
// which happens when areas end faster than the divider finishes them or
// when results are not popped. A finished result waits in an output register
// until popped while the divider and the front carry on.
// Register writes take effect at once and belong between areas; cfg_ready
// is always high. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module peak_pixel_centroid (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ppc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data,
    // pixel input, queue style
    input  logic                           push,
    output logic                           full,
    input  logic [ppc_pkg::PIXEL_W-1:0]    pixel_value,
    // results, queue style
    output logic                           empty,
    input  logic                           pop,
    output logic [ppc_pkg::CENTROID_W-1:0] centroid_x,
    output logic [ppc_pkg::CENTROID_W-1:0] centroid_y,
    output logic [ppc_pkg::PIXEL_W-1:0]    peak_value,
    output logic [ppc_pkg::CNT_W-1:0]      peak_count
);
    import ppc_pkg::*;

    logic      cfg_we;
    logic      pix_accept;
    logic      sum_push, q_pop, q_empty, q_full;
    area_sum_t sum_data, q_data;

    // Registers take a write every cycle
    assign cfg_ready  = 1'b1;
    assign cfg_we     = cfg_valid && cfg_ready;

    // Hold pixels back only when the queue cannot take another area
    assign full       = q_full;
    assign pix_accept = push && !q_full;

    ppc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_accept  (pix_accept),
        .pixel_value (pixel_value),
        .sum_push    (sum_push),
        .sum_data    (sum_data)
    );

    ppc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (sum_push),
        .wr_data (sum_data),
        .pop     (q_pop),
        .rd_data (q_data),
        .full    (q_full),
        .empty   (q_empty)
    );

    ppc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_data     (q_data),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y),
        .peak_value (peak_value),
        .peak_count (peak_count)
    );

endmodule
